>>> hw/rtl/wildcard_byte_pattern_scanner_core_assert.svh
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner: assertion macros
// Shared concurrent assertion macros. They vanish when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define WBPS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wbps assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wbps assertion failed");

`else

`define WBPS_ASSERT_SAME(label, clk, rst, ante, cons)
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/wbps_pkg.sv
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Constants, types and helper functions shared by the scanner files.
// ---------------------------------------------------------------------------
package wbps_pkg;

   // Pattern geometry.
   localparam int PATTERN_MAX = 16;
   localparam int LEN_W       = 5;
   localparam int IDX_W       = $clog2(PATTERN_MAX);
   localparam int COUNT_W     = 32;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;

   // Register indexes on the configuration port (byte address is 8 times the index).
   typedef enum logic [2:0] {
      REG_VALUE_LOW      = 3'd0,
      REG_VALUE_HIGH     = 3'd1,
      REG_MASK_LOW       = 3'd2,
      REG_MASK_HIGH      = 3'd3,
      REG_PATTERN_LENGTH = 3'd4
   } reg_index_type;

   typedef logic [PATTERN_MAX-1:0][7:0] byte_row_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      byte_row_type     value;
      byte_row_type     mask;
      logic [LEN_W-1:0] act_len;
   } cfg_type;

   // Length in use: zero acts as one, anything above the maximum as the maximum.
   function automatic logic [LEN_W-1:0] active_length(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] res;
      res = len;
      if (len == '0) begin
         res = LEN_W'(1);
      end else if (len > LEN_W'(PATTERN_MAX)) begin
         res = LEN_W'(PATTERN_MAX);
      end
      return res;
   endfunction

endpackage

>>> hw/rtl/wbps_if.sv
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner channel interfaces
// Valid/ready channels for the input bytes and the scan results.
// ---------------------------------------------------------------------------
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_start;

   modport source (output valid, output data_byte, output buffer_start, input ready);
   modport sink   (input valid, input data_byte, input buffer_start, output ready);
endinterface

interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        window_match;
   logic        found;
   logic [31:0] first_offset;

   modport source (output valid, output window_match, output found,
                   output first_offset, input ready);
   modport sink   (input valid, input window_match, input found,
                   input first_offset, output ready);
endinterface

>>> hw/rtl/wbps_csr.sv
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner register file
// APB-style register bank holding the pattern values, masks and length.
// ---------------------------------------------------------------------------
module wbps_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wbps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wbps_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output wbps_pkg::cfg_type                 cfg
);
   import wbps_pkg::*;

   logic [CSR_DATA_W-1:0] value_low_ff,  value_low_in;
   logic [CSR_DATA_W-1:0] value_high_ff, value_high_in;
   logic [CSR_DATA_W-1:0] mask_low_ff,   mask_low_in;
   logic [CSR_DATA_W-1:0] mask_high_ff,  mask_high_in;
   logic [LEN_W-1:0]      len_ff,        len_in;
   logic                  wr_en;
   reg_index_type         reg_idx;
   logic                  addr_hi;

   // Registers sit at 8-byte strides; the upper address bit is beyond the list.
   assign reg_idx    = reg_index_type'(csr_paddr[5:3]);
   assign addr_hi    = 1'b0;
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready && !addr_hi;

   // Next register values on a write transfer.
   always_comb begin
      value_low_in  = value_low_ff;
      value_high_in = value_high_ff;
      mask_low_in   = mask_low_ff;
      mask_high_in  = mask_high_ff;
      len_in        = len_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_VALUE_LOW:      value_low_in  = csr_pwdata;
            REG_VALUE_HIGH:     value_high_in = csr_pwdata;
            REG_MASK_LOW:       mask_low_in   = csr_pwdata;
            REG_MASK_HIGH:      mask_high_in  = csr_pwdata;
            REG_PATTERN_LENGTH: len_in        = csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Register bank.
   always_ff @(posedge clock) begin
      if (reset) begin
         value_low_ff  <= '0;
         value_high_ff <= '0;
         mask_low_ff   <= '0;
         mask_high_ff  <= '0;
         len_ff        <= LEN_W'(1);
      end else begin
         value_low_ff  <= value_low_in;
         value_high_ff <= value_high_in;
         mask_low_ff   <= mask_low_in;
         mask_high_ff  <= mask_high_in;
         len_ff        <= len_in;
      end
   end

   // Read-back multiplexer.
   always_comb begin
      case (reg_idx)
         REG_VALUE_LOW:      csr_prdata = value_low_ff;
         REG_VALUE_HIGH:     csr_prdata = value_high_ff;
         REG_MASK_LOW:       csr_prdata = mask_low_ff;
         REG_MASK_HIGH:      csr_prdata = mask_high_ff;
         REG_PATTERN_LENGTH: csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, len_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // Configuration as the datapath sees it.
   assign cfg.value   = {value_high_ff, value_low_ff};
   assign cfg.mask    = {mask_high_ff, mask_low_ff};
   assign cfg.act_len = active_length(len_ff);

endmodule

>>> hw/rtl/wbps_match.sv
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner window compare
// Masked compare of the pattern against the newest bytes of the window.
// ---------------------------------------------------------------------------
module wbps_match (
   input  wbps_pkg::byte_row_type window,
   input  wbps_pkg::cfg_type      cfg,
   output logic                   bytes_equal
);
   import wbps_pkg::*;

   logic [PATTERN_MAX-1:0] byte_ok;

   // Pattern byte i lines up with window entry len-1-i (entry 0 is the newest byte).
   // Pattern bytes at or beyond the active length always pass.
   always_comb begin
      logic [LEN_W-1:0] pos;
      logic [IDX_W-1:0] idx;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pos = cfg.act_len - LEN_W'(i) - LEN_W'(1);
         idx = pos[IDX_W-1:0];
         byte_ok[i] = (LEN_W'(i) >= cfg.act_len) ||
                      ((window[idx] & cfg.mask[i]) == (cfg.value[i] & cfg.mask[i]));
      end
   end

   assign bytes_equal = &byte_ok;

endmodule

>>> hw/rtl/wildcard_byte_pattern_scanner_core.sv
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner core
// Streams bytes through a masked pattern compare and tracks the first match.
// ---------------------------------------------------------------------------
// Usage:
// Bytes arrive on the req channel, one per transfer; buffer_start marks the
// first byte of a new buffer and clears the byte count and the first match.
// Each byte gives exactly one result transfer on the rsp channel: whether the
// pattern matches the bytes ending at it, whether a match has been seen in the
// buffer, and the start offset of the first match (zero until one is found).
// The user sets the pattern through the csr port while the block is idle; the
// block itself does not enforce this. An accepted byte waits in the input
// register, then passes the window compare into the result register, from
// which its result transfers. Throughput is one byte per cycle while the
// result side takes its results; the masked compare of all sixteen window
// bytes at once is combinational.
// With the result side stalled, the input register still takes one more byte,
// after which req ready drops until the result is taken.
// Reset clears the valid flags of both pipeline registers, the byte count, the
// match state and the configuration (length one, all masks and values zero).
// ---------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_core (
   input  logic                            clock,
   input  logic                            reset,
   wbps_req_if.sink                        req_if,
   wbps_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wbps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wbps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wbps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import wbps_pkg::*;

   `include "wildcard_byte_pattern_scanner_core_assert.svh"

   cfg_type cfg;

   // Input register.
   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff,  in_byte_in;
   logic               in_start_ff, in_start_in;

   // Scan state.
   byte_row_type       window_ff,   window_in;
   logic [COUNT_W-1:0] count_ff,    count_in;
   logic               seen_ff,     seen_in;
   logic [COUNT_W-1:0] mstart_ff,   mstart_in;

   // Result register.
   logic               out_valid_ff, out_valid_in;
   logic               out_match_ff, out_match_in;
   logic               out_found_ff, out_found_in;
   logic [COUNT_W-1:0] out_offset_ff, out_offset_in;

   logic               out_advance;
   logic               process;
   logic               req_take;
   logic [COUNT_W-1:0] count_base;
   logic               bytes_equal;
   logic               hit;

   // Configuration registers.
   wbps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Pipeline flow control: each stage moves when the one after it can take it.
   assign out_advance  = !out_valid_ff || rsp_if.ready;
   assign process      = in_valid_ff && out_advance;
   assign req_if.ready = !in_valid_ff || out_advance;
   assign req_take     = req_if.valid && req_if.ready;

   // Input register next values.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_start_in = in_start_ff;
      if (process) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.data_byte;
         in_start_in = req_if.buffer_start;
      end
   end

   // Window shifts in the new byte at entry 0.
   always_comb begin
      window_in = window_ff;
      if (process) begin
         window_in = {window_ff[PATTERN_MAX-2:0], in_byte_ff};
      end
   end

   // Saturating byte count, restarted at a buffer start.
   always_comb begin
      count_base = in_start_ff ? '0 : count_ff;
      count_in   = count_ff;
      if (process) begin
         count_in = (count_base == '1) ? count_base : count_base + COUNT_W'(1);
      end
   end

   wbps_match u_match (
      .window      (window_in),
      .cfg         (cfg),
      .bytes_equal (bytes_equal)
   );

   // A match needs enough bytes of this buffer to fill the pattern.
   assign hit = bytes_equal && (count_in >= COUNT_W'(cfg.act_len));

   // First-match tracking and the next result.
   always_comb begin
      seen_in       = seen_ff;
      mstart_in     = mstart_ff;
      out_valid_in  = out_valid_ff;
      out_match_in  = out_match_ff;
      out_found_in  = out_found_ff;
      out_offset_in = out_offset_ff;
      if (out_advance) begin
         out_valid_in = 1'b0;
      end
      if (process) begin
         if (in_start_ff) begin
            seen_in   = 1'b0;
            mstart_in = '0;
         end
         if (hit && !seen_in) begin
            seen_in   = 1'b1;
            mstart_in = count_in - COUNT_W'(cfg.act_len);
         end
         out_valid_in  = 1'b1;
         out_match_in  = hit;
         out_found_in  = seen_in;
         out_offset_in = seen_in ? mstart_in : '0;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         window_ff    <= '0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         mstart_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         mstart_ff    <= mstart_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_start_ff   <= in_start_in;
      out_match_ff  <= out_match_in;
      out_found_ff  <= out_found_in;
      out_offset_ff <= out_offset_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.window_match = out_match_ff;
   assign rsp_if.found        = out_found_ff;
   assign rsp_if.first_offset = out_offset_ff;

   // Checks on the scan logic.
   `WBPS_ASSERT_SAME(a_match_implies_found, clock, reset,
      out_valid_ff && out_match_ff, out_found_ff)
   `WBPS_ASSERT_SAME(a_offset_zero_until_found, clock, reset,
      out_valid_ff && !out_found_ff, out_offset_ff == '0)
   `WBPS_ASSERT_NEXT(a_seen_kept_within_buffer, clock, reset,
      seen_ff && !(process && in_start_ff), seen_ff)
   `WBPS_ASSERT_SAME(a_stall_means_both_full, clock, reset,
      !req_if.ready, in_valid_ff && out_valid_ff)

endmodule
